>>> hw/rtl/kau_pkg.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver package
// Byte codes, result kinds and the types shared by the receiver modules.
// ----------------------------------------------------------------------------
package kau_pkg;

	localparam int MAX_DIGIPEATERS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF     = 2;

	// KISS framing codes
	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;
	localparam logic [7:0] CMD_PORT_MASK = 8'h0F;

	// AX.25 header codes
	localparam logic [7:0] ADDR_SSID_MASK = 8'h60;
	localparam logic [7:0] ADDR_LAST_MASK = 8'h01;
	localparam logic [7:0] CTRL_UI        = 8'h03;
	localparam logic [7:0] PID_NO_L3      = 8'hF0;
	localparam logic [2:0] ADDR_LAST_BYTE = 3'd6;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_REJECT  = 2'd2,
		KIND_DISCARD = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

>>> hw/rtl/kau_channels.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver channels
// Valid/ready channels for raw link bytes and for result items.
// ----------------------------------------------------------------------------
interface kau_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kau_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

>>> hw/rtl/kau_queue.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver result queue
// Short first-in first-out queue between the decoder and the output stage.
// ----------------------------------------------------------------------------
module kau_queue #(
	parameter int DEPTH = kau_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  kau_pkg::result_t      push_item,
	input  logic                  pop,
	output kau_pkg::result_t      head,
	output kau_pkg::queue_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	kau_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/kau_front.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver decoder
// KISS deframing, escapes, AX.25 UI header check; a byte a cycle while ready.
// ----------------------------------------------------------------------------
module kau_front #(
	parameter int MAX_DIGIPEATERS = kau_pkg::MAX_DIGIPEATERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	kau_in_if.sink            in_ch,
	input  logic              queue_full,
	output logic              push,
	output kau_pkg::result_t  push_item
);

	typedef enum logic [3:0] {
		PH_ADDR    = 4'b0001,
		PH_CTRL    = 4'b0010,
		PH_PID     = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	// Destination and source plus the digipeaters.
	localparam logic [3:0] ADDR_LIMIT = 4'(2 + MAX_DIGIPEATERS);

	logic       framing_q,   framing_d;
	logic       esc_pending_q, esc_pending_d;
	logic       expect_cmd_q, expect_cmd_d;
	logic       nonempty_q,  nonempty_d;
	phase_t     phase_q,     phase_d;
	logic [2:0] addr_idx_q,  addr_idx_d;
	logic [3:0] addr_cnt_q,  addr_cnt_d;
	logic       hdr_err_q,   hdr_err_d;

	logic       accept;
	logic       do_clear;
	logic       take;
	logic [7:0] rx;
	logic [7:0] dec;
	logic [3:0] cnt_inc;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign rx          = in_ch.rx_byte;
	assign cnt_inc     = addr_cnt_q + 4'd1;

	always_comb begin
		framing_d     = framing_q;
		esc_pending_d = esc_pending_q;
		expect_cmd_d  = expect_cmd_q;
		nonempty_d    = nonempty_q;
		phase_d       = phase_q;
		addr_idx_d    = addr_idx_q;
		addr_cnt_d    = addr_cnt_q;
		hdr_err_d     = hdr_err_q;
		do_clear      = 1'b0;
		take          = 1'b0;
		dec           = rx;
		push          = 1'b0;
		push_item.kind      = kau_pkg::KIND_PAYLOAD;
		push_item.data_byte = rx;

		if (rx == kau_pkg::FEND) begin
			if (nonempty_q) begin
				push = accept;
				push_item.kind = (phase_q == PH_PAYLOAD && !hdr_err_q) ?
					kau_pkg::KIND_ACCEPT : kau_pkg::KIND_REJECT;
				framing_d     = 1'b0;
				esc_pending_d = 1'b0;
				expect_cmd_d  = 1'b0;
				do_clear      = 1'b1;
			end else begin
				expect_cmd_d = 1'b1;
			end
		end else if (expect_cmd_q) begin
			if ((rx & kau_pkg::CMD_PORT_MASK) == 8'h00) begin
				framing_d = 1'b1;
			end
			expect_cmd_d = 1'b0;
		end else if (framing_q) begin
			if (rx == kau_pkg::FESC) begin
				if (esc_pending_q) begin
					// A second escape in a row drops the frame but keeps framing.
					esc_pending_d  = 1'b0;
					do_clear       = 1'b1;
					push           = accept;
					push_item.kind = kau_pkg::KIND_DISCARD;
				end else begin
					esc_pending_d = 1'b1;
				end
			end else if (esc_pending_q) begin
				esc_pending_d = 1'b0;
				if (rx == kau_pkg::TFEND) begin
					dec  = kau_pkg::FEND;
					take = 1'b1;
				end else if (rx == kau_pkg::TFESC) begin
					dec  = kau_pkg::FESC;
					take = 1'b1;
				end else begin
					framing_d      = 1'b0;
					do_clear       = 1'b1;
					push           = accept;
					push_item.kind = kau_pkg::KIND_DISCARD;
				end
			end else begin
				take = 1'b1;
			end
		end

		if (take) begin
			nonempty_d = 1'b1;
			push_item.data_byte = dec;
			if (!hdr_err_q) begin
				case (phase_q)
					PH_ADDR: begin
						if (addr_idx_q != kau_pkg::ADDR_LAST_BYTE) begin
							addr_idx_d = addr_idx_q + 3'd1;
						end else begin
							addr_idx_d = '0;
							addr_cnt_d = cnt_inc;
							if ((dec & kau_pkg::ADDR_SSID_MASK) != kau_pkg::ADDR_SSID_MASK) begin
								hdr_err_d = 1'b1;
							end else if (cnt_inc >= 4'd2 &&
									(dec & kau_pkg::ADDR_LAST_MASK) != 8'h00) begin
								phase_d = PH_CTRL;
							end else if (cnt_inc >= ADDR_LIMIT) begin
								hdr_err_d = 1'b1;
							end
						end
					end
					PH_CTRL: begin
						if (dec != kau_pkg::CTRL_UI) begin
							hdr_err_d = 1'b1;
						end else begin
							phase_d = PH_PID;
						end
					end
					PH_PID: begin
						if (dec != kau_pkg::PID_NO_L3) begin
							hdr_err_d = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
					default: begin
						push = accept;
					end
				endcase
			end
		end

		if (do_clear) begin
			nonempty_d = 1'b0;
			phase_d    = PH_ADDR;
			addr_idx_d = '0;
			addr_cnt_d = '0;
			hdr_err_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_q     <= 1'b0;
			esc_pending_q <= 1'b0;
			expect_cmd_q  <= 1'b0;
			nonempty_q    <= 1'b0;
			phase_q       <= PH_ADDR;
			addr_idx_q    <= '0;
			addr_cnt_q    <= '0;
			hdr_err_q     <= 1'b0;
		end else if (accept) begin
			framing_q     <= framing_d;
			esc_pending_q <= esc_pending_d;
			expect_cmd_q  <= expect_cmd_d;
			nonempty_q    <= nonempty_d;
			phase_q       <= phase_d;
			addr_idx_q    <= addr_idx_d;
			addr_cnt_q    <= addr_cnt_d;
			hdr_err_q     <= hdr_err_d;
		end
	end

endmodule

>>> hw/rtl/kau_back.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver output stage
// Drains the result queue into the output register and formats each item.
// ----------------------------------------------------------------------------
module kau_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_empty,
	input  kau_pkg::result_t  head,
	output logic              pop,
	kau_out_if.source         out_ch
);

	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_data_q;

	assign pop = !queue_empty && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Markers carry a zero data byte.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_kind_q <= head.kind;
			out_data_q <= (head.kind == kau_pkg::KIND_PAYLOAD) ? head.data_byte : 8'h00;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.kind      = out_kind_q;
	assign out_ch.data_byte = out_data_q;

endmodule

>>> hw/rtl/kiss_ax25_ui_receiver_unit.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver
// Deframes a KISS byte stream, checks the AX.25 UI header and emits payload
// bytes followed by an end-of-frame marker.
//
//   channel  direction  payload               transfer when
//   in_ch    sink       rx_byte[7:0]          valid && ready
//   out_ch   source     kind[1:0], data_byte  valid && ready
//
// One raw byte is taken every cycle while in_ch.ready is high; the decoder
// state machine settles a byte in the cycle of its transfer. A result goes
// through the queue and the output register to out_ch. A two-entry queue
// and the output register absorb stalls on out_ch; in_ch.ready drops only
// while the queue is full. Reset clears all framing and header state at once.
// ----------------------------------------------------------------------------
module kiss_ax25_ui_receiver_unit #(
	parameter int MAX_DIGIPEATERS = kau_pkg::MAX_DIGIPEATERS_DEF,
	parameter int QUEUE_DEPTH     = kau_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kau_in_if.sink      in_ch,
	kau_out_if.source   out_ch
);

	logic                  push;
	logic                  pop;
	kau_pkg::result_t      push_item;
	kau_pkg::result_t      head;
	kau_pkg::queue_stat_t  stat;

	kau_front #(
		.MAX_DIGIPEATERS (MAX_DIGIPEATERS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.queue_full (stat.full),
		.push       (push),
		.push_item  (push_item)
	);

	kau_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	kau_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (stat.empty),
		.head        (head),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule

>>> hw/rtl/kau_checker.sv
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver checker
// Port-level properties of the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module kau_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_data
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_data))
		else $error("stalled result changed");

	// Frame markers never carry data.
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != kau_pkg::KIND_PAYLOAD |-> out_data == 8'h00)
		else $error("marker with nonzero data byte");

	// With nothing waiting at the output the queue cannot be full.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

endmodule

bind kiss_ax25_ui_receiver_unit kau_checker u_kau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_kind  (out_ch.kind),
	.out_data  (out_ch.data_byte)
);

>>> dv/kiss_ax25_ui_receiver_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS AX.25 UI receiver testbench
// Feeds raw link bytes through a directed table and then random frames, some
// well formed and some broken. Each transfer is decoded by a local deframer
// and header checker, and the result stream is compared in order, with bursty
// input, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module kiss_ax25_ui_receiver_unit_test;
	import kau_pkg::*;

	localparam int MAX_DIGIS    = MAX_DIGIPEATERS_DEF;
	localparam int RANDOM_ITEMS = 1370;
	localparam int PRESSURE_AT  = 400;
	localparam int LONG_HOLD    = 400;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [1:0] {
		HDR_ADDRESS,
		HDR_CONTROL,
		HDR_PID,
		HDR_PAYLOAD
	} hdr_phase_t;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_FIXED
	} check_mode_t;

	typedef enum logic [1:0] {
		RX_STREAM,
		RX_PATTERN,
		RX_RANDOM
	} stall_mode_t;

	typedef struct {
		bit         framing;
		bit         esc_pending;
		bit         expect_command;
		bit         frame_nonempty;
		hdr_phase_t header_phase;
		logic [2:0] addr_byte_idx;
		logic [3:0] addr_count;
		bit         header_error;
	} deframer_state_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		check_mode_t mode;
		result_t     fixed;
	} link_item_t;

	localparam result_t NO_RESULT    = '{KIND_PAYLOAD, 8'h00};
	localparam result_t ACCEPT_MARK  = '{KIND_ACCEPT, 8'h00};
	localparam result_t REJECT_MARK  = '{KIND_REJECT, 8'h00};
	localparam result_t DISCARD_MARK = '{KIND_DISCARD, 8'h00};

	localparam int DIRECTED_ROWS = 37;

	// Rows with a typed expectation are checked against that value; the
	// payload rows are left to the decoder below.
	link_item_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h55, CHK_NONE, NO_RESULT},        // ignored outside a frame
		'{FEND, CHK_NONE, NO_RESULT},
		'{8'h0F, CHK_NONE, NO_RESULT},        // nonzero port, frame not opened
		'{FEND, CHK_NONE, NO_RESULT},
		'{8'h00, CHK_NONE, NO_RESULT},
		'{FESC, CHK_NONE, NO_RESULT},
		'{FESC, CHK_FIXED, DISCARD_MARK},     // double escape stays in frame
		'{FESC, CHK_NONE, NO_RESULT},
		'{8'hFF, CHK_FIXED, DISCARD_MARK},    // bad escape leaves the frame
		'{FEND, CHK_NONE, NO_RESULT},
		'{8'hF0, CHK_NONE, NO_RESULT},
		'{8'h88, CHK_NONE, NO_RESULT},
		'{8'h8A, CHK_NONE, NO_RESULT},
		'{8'hA4, CHK_NONE, NO_RESULT},
		'{8'hA4, CHK_NONE, NO_RESULT},
		'{8'hB2, CHK_NONE, NO_RESULT},
		'{8'h40, CHK_NONE, NO_RESULT},
		'{8'hE1, CHK_NONE, NO_RESULT},        // last mark on destination ignored
		'{8'h9C, CHK_NONE, NO_RESULT},
		'{8'h9E, CHK_NONE, NO_RESULT},
		'{8'h86, CHK_NONE, NO_RESULT},
		'{8'h40, CHK_NONE, NO_RESULT},
		'{8'h40, CHK_NONE, NO_RESULT},
		'{8'h40, CHK_NONE, NO_RESULT},
		'{8'h61, CHK_NONE, NO_RESULT},
		'{CTRL_UI, CHK_NONE, NO_RESULT},
		'{PID_NO_L3, CHK_NONE, NO_RESULT},
		'{FESC, CHK_NONE, NO_RESULT},
		'{TFEND, CHK_PREDICT, NO_RESULT},
		'{FESC, CHK_NONE, NO_RESULT},
		'{TFESC, CHK_PREDICT, NO_RESULT},
		'{8'hFF, CHK_PREDICT, NO_RESULT},
		'{FEND, CHK_FIXED, ACCEPT_MARK},
		'{FEND, CHK_NONE, NO_RESULT},
		'{8'h00, CHK_NONE, NO_RESULT},
		'{8'h12, CHK_NONE, NO_RESULT},
		'{FEND, CHK_FIXED, REJECT_MARK}       // frame ends inside the header
	};

	logic clk = 1'b0;
	logic arst_n;

	kau_in_if  in_ch();
	kau_out_if out_ch();

	kiss_ax25_ui_receiver_unit #(
		.MAX_DIGIPEATERS(MAX_DIGIS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	deframer_state_t link_state;
	result_t         expected_results[$];
	link_item_t      cur_item;
	int              burst_left = 0;
	int              items_sent = 0;
	int              mismatch_count = 0;
	int              quiet_cycles = 0;
	bit              pressure_go = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_frame_state();
		link_state.frame_nonempty = 1'b0;
		link_state.header_phase   = HDR_ADDRESS;
		link_state.addr_byte_idx  = '0;
		link_state.addr_count     = '0;
		link_state.header_error   = 1'b0;
	endfunction

	function automatic void reset_link_state();
		link_state.framing        = 1'b0;
		link_state.esc_pending    = 1'b0;
		link_state.expect_command = 1'b0;
		clear_frame_state();
	endfunction

	// Advances the deframer by one raw byte; returns 1 when a result is due.
	function automatic bit decode_link_byte(input logic [7:0] rx, output result_t res);
		logic [7:0] b;
		b = rx;
		res = NO_RESULT;
		if (b == FEND) begin
			if (link_state.frame_nonempty) begin
				res.kind = (link_state.header_phase == HDR_PAYLOAD && !link_state.header_error) ?
					KIND_ACCEPT : KIND_REJECT;
				reset_link_state();
				return 1'b1;
			end
			link_state.expect_command = 1'b1;
			return 1'b0;
		end
		if (link_state.expect_command) begin
			if ((b & CMD_PORT_MASK) == 8'h00)
				link_state.framing = 1'b1;
			link_state.expect_command = 1'b0;
			return 1'b0;
		end
		if (!link_state.framing)
			return 1'b0;
		if (b == FESC) begin
			if (link_state.esc_pending) begin
				link_state.esc_pending = 1'b0;
				clear_frame_state();
				res.kind = KIND_DISCARD;
				return 1'b1;
			end
			link_state.esc_pending = 1'b1;
			return 1'b0;
		end
		if (link_state.esc_pending) begin
			link_state.esc_pending = 1'b0;
			if (b == TFEND) begin
				b = FEND;
			end else if (b == TFESC) begin
				b = FESC;
			end else begin
				link_state.framing = 1'b0;
				clear_frame_state();
				res.kind = KIND_DISCARD;
				return 1'b1;
			end
		end
		link_state.frame_nonempty = 1'b1;
		if (link_state.header_error)
			return 1'b0;
		case (link_state.header_phase)
			HDR_ADDRESS: begin
				if (link_state.addr_byte_idx < ADDR_LAST_BYTE) begin
					link_state.addr_byte_idx = link_state.addr_byte_idx + 3'd1;
					return 1'b0;
				end
				link_state.addr_byte_idx = '0;
				link_state.addr_count = link_state.addr_count + 4'd1;
				if ((b & ADDR_SSID_MASK) != ADDR_SSID_MASK)
					link_state.header_error = 1'b1;
				else if (link_state.addr_count >= 4'd2 && (b & ADDR_LAST_MASK) != 8'h00)
					link_state.header_phase = HDR_CONTROL;
				else if (int'(link_state.addr_count) >= 2 + MAX_DIGIS)
					link_state.header_error = 1'b1;
				return 1'b0;
			end
			HDR_CONTROL: begin
				if (b != CTRL_UI)
					link_state.header_error = 1'b1;
				else
					link_state.header_phase = HDR_PID;
				return 1'b0;
			end
			HDR_PID: begin
				if (b != PID_NO_L3)
					link_state.header_error = 1'b1;
				else
					link_state.header_phase = HDR_PAYLOAD;
				return 1'b0;
			end
			default: begin
				res.data_byte = b;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Input and output transfers are handled in one block, input first, so a
	// same-edge result still finds its expectation in place.
	always @(posedge clk) begin
		result_t res;
		result_t want;
		bit      due;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				due = decode_link_byte(in_ch.rx_byte, res);
				case (cur_item.mode)
					CHK_PREDICT: if (due) expected_results.push_back(res);
					CHK_FIXED:   expected_results.push_back(cur_item.fixed);
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d data %02h",
						out_ch.kind, out_ch.data_byte));
				end else begin
					want = expected_results.pop_front();
					if (out_ch.kind !== want.kind || out_ch.data_byte !== want.data_byte)
						report_mismatch($sformatf(
							"result mismatch: expected kind %0d data %02h, got kind %0d data %02h",
							want.kind, want.data_byte, out_ch.kind, out_ch.data_byte));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: phases of steady flow, a rotating stall pattern and random
	// stalls, plus one long hold-off once the sender is well under way.
	initial begin
		stall_mode_t mode;
		logic [15:0] pattern;
		int          phase_left;
		bit          held;
		out_ch.ready <= 1'b0;
		mode = RX_STREAM;
		pattern = '1;
		phase_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pressure_go && !held) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (phase_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 2));
				phase_left = $urandom_range(20, 200);
				pattern = 16'($urandom) | 16'h0001;
			end
			phase_left--;
			case (mode)
				RX_PATTERN: begin
					out_ch.ready <= pattern[0];
					pattern = {pattern[0], pattern[15:1]};
				end
				RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default:   out_ch.ready <= 1'b1;
			endcase
		end
	end

	// The sender offers items in bursts; a gap between bursts is never empty,
	// so valid never drops and rises within the same edge.
	task automatic drive_item(input link_item_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = $urandom_range(1, 6);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= item.rx_byte;
		cur_item      <= item;
		do
			@(posedge clk);
		while (!in_ch.ready);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_raw(input logic [7:0] b);
		drive_item('{b, CHK_PREDICT, NO_RESULT});
	endtask

	task automatic send_decoded(input logic [7:0] b);
		if (b == FEND) begin
			send_raw(FESC);
			send_raw(TFEND);
		end else if (b == FESC) begin
			send_raw(FESC);
			send_raw(TFESC);
		end else begin
			send_raw(b);
		end
	endtask

	// Mostly well-formed UI frames with random content; a minority carry a
	// bad command, bad address bits, too many digipeaters, a wrong control
	// or PID, broken escapes or a missing closing delimiter.
	task automatic send_random_frame();
		int         n_addr;
		int         n_payload;
		logic [7:0] ssid;
		send_raw(FEND);
		if ($urandom_range(0, 9) == 0)
			send_raw(8'($urandom));
		else
			send_raw(8'($urandom_range(0, 15) << 4));
		if ($urandom_range(0, 15) == 0)
			n_addr = 3 + MAX_DIGIS + $urandom_range(0, 2);
		else
			n_addr = 2 + $urandom_range(0, MAX_DIGIS);
		for (int a = 0; a < n_addr; a++) begin
			repeat (6) send_decoded(8'($urandom));
			ssid = 8'($urandom) | ADDR_SSID_MASK;
			if (a != 0)
				ssid = (a == n_addr - 1) ? (ssid | ADDR_LAST_MASK) : (ssid & ~ADDR_LAST_MASK);
			if ($urandom_range(0, 39) == 0)
				ssid = (ssid & ~ADDR_SSID_MASK) | 8'($urandom_range(0, 2) << 5);
			if ($urandom_range(0, 39) == 0)
				ssid = ssid ^ ADDR_LAST_MASK;
			send_decoded(ssid);
		end
		send_decoded(($urandom_range(0, 19) == 0) ? 8'($urandom) : CTRL_UI);
		send_decoded(($urandom_range(0, 19) == 0) ? 8'($urandom) : PID_NO_L3);
		n_payload = $urandom_range(0, 16);
		repeat (n_payload) begin
			if ($urandom_range(0, 29) == 0) begin
				send_raw(FESC);
				send_raw(($urandom_range(0, 1) == 0) ? FESC : 8'($urandom));
			end else if ($urandom_range(0, 7) == 0) begin
				send_decoded(($urandom_range(0, 1) == 0) ? FEND : FESC);
			end else begin
				send_decoded(8'($urandom));
			end
		end
		if ($urandom_range(0, 19) != 0)
			send_raw(FEND);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) send_raw(8'($urandom));
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.rx_byte <= 8'h00;
		cur_item      <= '{8'h00, CHK_NONE, NO_RESULT};
		reset_link_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_item(directed_rows[i]);

		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			if (items_sent >= PRESSURE_AT)
				pressure_go <= 1'b1;
			send_random_frame();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
